FILE: sv/ptt_pkg.sv
// ============================================================================
// ptt_pkg
// Types and codes used by the periodic timer table.
// ============================================================================
`default_nettype none

package ptt_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_ZERO_PERIOD = 2'd1;
    localparam logic [1:0] STAT_FULL        = 2'd2;
    localparam logic [1:0] STAT_EMPTY       = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  owner;
        logic [15:0] timer_id;
        logic [1:0]  mode;
        logic [15:0] period;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  fire_owner;
        logic [15:0] fire_id;
        logic [1:0]  fire_action;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

FILE: sv/ptt_ram.sv
// ============================================================================
// ptt_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/periodic_timer_table_unit.sv
// A set, or a delete on an empty table, goes through the acknowledge state, and its acknowledge
// is registered in the output register, held while the output is stalled. A delete reads and
// compares the stored entries in order; a removal then moves each later entry up one place.
// A tick visits each stored entry in order to update its count, and can wait while the output is stalled.
// One transaction is worked at a time; the single read port of the entry memory sets the pace.
// Reset empties the table at once through the entry count; no clearing pass is needed.
// ============================================================================
// periodic_timer_table_unit
// Insertion-ordered table of periodic timers that emits fire events on ticks.
// ============================================================================
`default_nettype none

module periodic_timer_table_unit #(
    parameter int TIMER_ENTRIES = 16,
    parameter int PERIOD_BITS   = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ptt_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ptt_pkg::t_out      o_out_data
);

    import ptt_pkg::*;

    localparam int IW       = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam int CW       = $clog2(TIMER_ENTRIES + 1);
    localparam int PB       = PERIOD_BITS;
    localparam int PER_LSB  = PB;
    localparam int MODE_LSB = 2 * PB;
    localparam int ID_LSB   = 2 * PB + 2;
    localparam int OWN_LSB  = 2 * PB + 18;
    localparam int EW       = 2 * PB + 26;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACK    = 3'd1;
    localparam logic [2:0] ST_TEV    = 3'd2;
    localparam logic [2:0] ST_TEND   = 3'd3;
    localparam logic [2:0] ST_DCMP   = 3'd4;
    localparam logic [2:0] ST_DSHIFT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_total, n_total;
    logic          r_append, n_append;
    logic          r_hold_valid, n_hold_valid;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic [7:0]    r_owner, n_owner;
    logic [15:0]   r_id, n_id;
    logic [1:0]    r_mode, n_mode;
    logic [PB-1:0] r_period, n_period;
    logic [1:0]    r_ack_kind, n_ack_kind;
    logic [1:0]    r_ack_status, n_ack_status;
    logic [7:0]    r_hold_owner, n_hold_owner;
    logic [15:0]   r_hold_id, n_hold_id;
    logic [1:0]    r_hold_mode, n_hold_mode;

    logic          w_wr_en, w_rd_en;
    logic [IW-1:0] w_wr_addr, w_rd_addr;
    logic [EW-1:0] w_wr_data, w_rd_data;

    logic [PB-1:0] w_in_period;
    logic [CW-1:0] w_idx_next, w_idx_next2;
    logic          w_more, w_out_free, w_due, w_match;
    logic [7:0]    w_rd_owner;
    logic [15:0]   w_rd_id;
    logic [1:0]    w_rd_mode;
    logic [PB-1:0] w_rd_period, w_rd_count;

    ptt_ram #(
        .WIDTH(EW),
        .DEPTH(TIMER_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_in_period = PB'(i_in_data.period);
    assign w_idx_next  = CW'(r_idx) + CW'(1);
    assign w_idx_next2 = CW'(r_idx) + CW'(2);
    assign w_more      = w_idx_next < r_total;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_rd_owner  = w_rd_data[OWN_LSB +: 8];
    assign w_rd_id     = w_rd_data[ID_LSB +: 16];
    assign w_rd_mode   = w_rd_data[MODE_LSB +: 2];
    assign w_rd_period = w_rd_data[PER_LSB +: PB];
    assign w_rd_count  = w_rd_data[0 +: PB];
    assign w_due       = w_rd_count == w_rd_period;
    assign w_match     = (w_rd_owner == r_owner) && (w_rd_id == r_id);

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_total      = r_total;
        n_append     = r_append;
        n_hold_valid = r_hold_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_owner      = r_owner;
        n_id         = r_id;
        n_mode       = r_mode;
        n_period     = r_period;
        n_ack_kind   = r_ack_kind;
        n_ack_status = r_ack_status;
        n_hold_owner = r_hold_owner;
        n_hold_id    = r_hold_id;
        n_hold_mode  = r_hold_mode;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = w_rd_data;
        w_rd_en      = 1'b0;
        w_rd_addr    = w_idx_next[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_owner  = i_in_data.owner;
                    n_id     = i_in_data.timer_id;
                    n_mode   = i_in_data.mode;
                    n_period = w_in_period;
                    n_idx    = '0;
                    n_append = 1'b0;
                    priority if (i_in_data.cmd == CMD_SET) begin
                        n_ack_kind = KIND_SET;
                        n_state    = ST_ACK;
                        priority if (w_in_period == '0) begin
                            n_ack_status = STAT_ZERO_PERIOD;
                        end else if (r_total >= CW'(TIMER_ENTRIES)) begin
                            n_ack_status = STAT_FULL;
                        end else begin
                            n_ack_status = STAT_OK;
                            n_append     = 1'b1;
                        end
                    end else if (i_in_data.cmd == CMD_DEL) begin
                        n_ack_kind = KIND_DEL;
                        if (r_total == '0) begin
                            n_ack_status = STAT_EMPTY;
                            n_state      = ST_ACK;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_state   = ST_DCMP;
                        end
                    end else if (i_in_data.cmd == CMD_TICK) begin
                        if (r_total != '0) begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_state   = ST_TEV;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ACK: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = r_ack_kind;
                    n_out.status      = r_ack_status;
                    n_out.fire_owner  = '0;
                    n_out.fire_id     = '0;
                    n_out.fire_action = '0;
                    n_out.last        = 1'b1;
                    if (r_append) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_total[IW-1:0];
                        w_wr_data = {r_owner, r_id, r_mode, r_period, PB'(1)};
                        n_total   = r_total + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_TEV: begin
                if (!(w_due && r_hold_valid) || w_out_free) begin
                    w_wr_en = 1'b1;
                    if (w_due) begin
                        w_wr_data = {w_rd_data[EW-1:PB], PB'(1)};
                        if (r_hold_valid) begin
                            n_out_valid       = 1'b1;
                            n_out.kind        = KIND_FIRE;
                            n_out.status      = STAT_OK;
                            n_out.fire_owner  = r_hold_owner;
                            n_out.fire_id     = r_hold_id;
                            n_out.fire_action = r_hold_mode;
                            n_out.last        = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_owner = w_rd_owner;
                        n_hold_id    = w_rd_id;
                        n_hold_mode  = w_rd_mode;
                    end else begin
                        w_wr_data = {w_rd_data[EW-1:PB], w_rd_count + PB'(1)};
                    end
                    if (w_more) begin
                        w_rd_en = 1'b1;
                        n_idx   = w_idx_next[IW-1:0];
                    end else begin
                        n_state = ST_TEND;
                    end
                end
            end
            ST_TEND: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_FIRE;
                    n_out.status      = STAT_OK;
                    n_out.fire_owner  = r_hold_owner;
                    n_out.fire_id     = r_hold_id;
                    n_out.fire_action = r_hold_mode;
                    n_out.last        = 1'b1;
                    n_hold_valid      = 1'b0;
                    n_state           = ST_IDLE;
                end
            end
            ST_DCMP: begin
                if (w_match) begin
                    w_rd_en = w_more;
                    n_state = ST_DSHIFT;
                end else if (w_more) begin
                    w_rd_en = 1'b1;
                    n_idx   = w_idx_next[IW-1:0];
                end else begin
                    n_ack_status = STAT_OK;
                    n_state      = ST_ACK;
                end
            end
            ST_DSHIFT: begin
                if (w_more) begin
                    w_wr_en   = 1'b1;
                    w_rd_en   = w_idx_next2 < r_total;
                    w_rd_addr = w_idx_next2[IW-1:0];
                    n_idx     = w_idx_next[IW-1:0];
                end else begin
                    n_total      = r_total - CW'(1);
                    n_ack_status = STAT_OK;
                    n_state      = ST_ACK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_total      <= '0;
            r_append     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_total      <= n_total;
            r_append     <= n_append;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_owner      <= n_owner;
        r_id         <= n_id;
        r_mode       <= n_mode;
        r_period     <= n_period;
        r_ack_kind   <= n_ack_kind;
        r_ack_status <= n_ack_status;
        r_hold_owner <= n_hold_owner;
        r_hold_id    <= n_hold_id;
        r_hold_mode  <= n_hold_mode;
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(TIMER_ENTRIES))
        else $error("Entry count exceeds the table size.");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEV || r_state == ST_DCMP) |-> (CW'(r_idx) < r_total))
        else $error("Walk index is outside the stored entries.");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("A fire event is left pending after a transaction.");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == ST_ACK || r_state == ST_TEV || r_state == ST_DSHIFT))
        else $error("Entry memory written outside an update step.");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != $past(r_total)) |-> ($past(r_state) == ST_ACK ||
                                         $past(r_state) == ST_DSHIFT))
        else $error("Entry count changed outside a set or delete.");

endmodule

`default_nettype wire
